/* hdl/rbps_pkg.sv */
// ----------------------------------------------------------------------------
// rbps_pkg
// Shared types, codes and defaults for the ready/blocked process scheduler.
// ----------------------------------------------------------------------------
package rbps_pkg;

  // Default sizes of the queues and of the process identifiers.
  localparam int QueueDepthDef = 16;
  localparam int IdBitsDef     = 16;

  // Fixed widths of the request and result fields.
  localparam int ReqW    = 3;
  localparam int PidW    = 16;
  localparam int StatusW = 2;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_CREATE    = 3'd0;
  localparam logic [ReqW-1:0] REQ_TERMINATE = 3'd1;
  localparam logic [ReqW-1:0] REQ_BLOCK     = 3'd2;
  localparam logic [ReqW-1:0] REQ_WAKE      = 3'd3;
  localparam logic [ReqW-1:0] REQ_QUERY     = 3'd4;

  // Status codes of a result.
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCMP,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage

/* hdl/ready_blocked_process_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// ready_blocked_process_scheduler_unit
// Single-processor scheduler with a FIFO ready queue and an ordered blocked
// list, both held in synchronous memories.
// ----------------------------------------------------------------------------
// Sequence: a request passes from S_EXEC to S_RESP, where done_o strobes; a
// promotion from the ready queue on terminate or block adds S_POP between them.
// Wake searches the blocked list in S_SCMP, comparing one entry per cycle, and
// when it finds the identifier and the ready queue can take the running process
// the tail of the list shifts down one per cycle in S_SHIFT; a full ready queue
// or an absent identifier ends the wake at S_RESP without the shift.
// A new request is taken in the cycle after the strobe (busy_o low); the receiver cannot stall.
// Reset empties both queues and leaves the block idle.
module ready_blocked_process_scheduler_unit
  import rbps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int ID_BITS     = IdBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [ReqW-1:0]    req_type_i,
  input  logic [PidW-1:0]    proc_id_i,
  output logic               done_o,
  output logic [PidW-1:0]    new_id_o,
  output logic               is_running_o,
  output logic               busy_res_o,
  output logic [PidW-1:0]    current_id_o,
  output logic [StatusW-1:0] status_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Control state.
  state_e             state_q, state_d;
  logic [ID_BITS-1:0] id_cnt_q, id_cnt_d;
  logic [ID_BITS-1:0] run_q, run_d;
  logic               run_vld_q, run_vld_d;
  logic [PW-1:0]      head_q, head_d;
  logic [PW-1:0]      tail_q, tail_d;
  logic [CW-1:0]      rq_cnt_q, rq_cnt_d;
  logic [CW-1:0]      bl_cnt_q, bl_cnt_d;
  logic [CW-1:0]      idx_q, idx_d;

  // Request and result payload.
  logic [ReqW-1:0]    req_q, req_d;
  logic [ID_BITS-1:0] pid_q, pid_d;
  logic [PidW-1:0]    new_id_q, new_id_d;
  logic               is_run_q, is_run_d;
  status_e            status_q, status_d;

  // Memory ports.
  logic [ID_BITS-1:0] ready_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] blk_mem   [QUEUE_DEPTH];
  logic [ID_BITS-1:0] ready_rd_q, blk_rd_q;
  logic               ready_we, blk_we;
  logic [PW-1:0]      ready_wa, blk_wa, blk_ra;
  logic [ID_BITS-1:0] ready_wd, blk_wd;

  logic               accept;
  logic [CW-1:0]      idx_inc, idx_inc2;
  logic [ID_BITS-1:0] id_next;
  logic               rq_full, bl_full, found;
  logic [PW-1:0]      tail_inc, head_inc;

  assign accept   = start_i && (state_q == S_IDLE);
  assign idx_inc  = idx_q + CW'(1);
  assign idx_inc2 = idx_q + CW'(2);
  assign id_next  = id_cnt_q + ID_BITS'(1);
  assign rq_full  = (rq_cnt_q == CW'(QUEUE_DEPTH));
  assign bl_full  = (bl_cnt_q == CW'(QUEUE_DEPTH));
  assign found    = (blk_rd_q == pid_q);
  assign tail_inc = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PW'(1);
  assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
        if (req_q == REQ_TERMINATE) begin
          if (rq_cnt_q != '0) state_d = S_POP;
        end else if (req_q == REQ_BLOCK) begin
          if (run_vld_q && !bl_full && (rq_cnt_q != '0)) state_d = S_POP;
        end else if (req_q == REQ_WAKE) begin
          if (bl_cnt_q != '0) state_d = S_SCMP;
        end
      end
      S_POP: state_d = S_RESP;
      S_SCMP: begin
        if (found) begin
          if (!(run_vld_q && rq_full) && (idx_inc < bl_cnt_q)) state_d = S_SHIFT;
          else state_d = S_RESP;
        end else if (idx_inc >= bl_cnt_q) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (idx_inc >= bl_cnt_q) state_d = S_RESP;
      end
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    id_cnt_d  = id_cnt_q;
    run_d     = run_q;
    run_vld_d = run_vld_q;
    head_d    = head_q;
    tail_d    = tail_q;
    rq_cnt_d  = rq_cnt_q;
    bl_cnt_d  = bl_cnt_q;
    idx_d     = idx_q;
    req_d     = req_q;
    pid_d     = pid_q;
    new_id_d  = new_id_q;
    is_run_d  = is_run_q;
    status_d  = status_q;
    ready_we  = 1'b0;
    ready_wa  = tail_q;
    ready_wd  = run_q;
    blk_we    = 1'b0;
    blk_wa    = idx_q[PW-1:0];
    blk_wd    = blk_rd_q;
    blk_ra    = idx_inc[PW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d    = req_type_i;
          pid_d    = ID_BITS'(proc_id_i);
          new_id_d = '0;
          is_run_d = 1'b0;
          status_d = ST_OK;
        end
      end
      S_EXEC: begin
        // Start the blocked-list search at its first entry.
        blk_ra = '0;
        idx_d  = '0;
        unique case (req_q)
          REQ_CREATE: begin
            if (!run_vld_q) begin
              id_cnt_d  = id_next;
              run_d     = id_next;
              run_vld_d = 1'b1;
              new_id_d  = PidW'(id_next);
            end else if (rq_full) begin
              status_d = ST_FULL;
            end else begin
              id_cnt_d = id_next;
              ready_we = 1'b1;
              ready_wd = id_next;
              tail_d   = tail_inc;
              rq_cnt_d = rq_cnt_q + CW'(1);
              new_id_d = PidW'(id_next);
            end
          end
          REQ_TERMINATE: begin
            if (rq_cnt_q == '0) begin
              run_vld_d = 1'b0;
              run_d     = '0;
            end
          end
          REQ_BLOCK: begin
            if (!run_vld_q) begin
              status_d = ST_IGNORED;
            end else if (bl_full) begin
              status_d = ST_FULL;
            end else begin
              blk_we   = 1'b1;
              blk_wa   = bl_cnt_q[PW-1:0];
              blk_wd   = run_q;
              bl_cnt_d = bl_cnt_q + CW'(1);
              if (rq_cnt_q == '0) begin
                run_vld_d = 1'b0;
                run_d     = '0;
              end
            end
          end
          REQ_WAKE: begin
            if (bl_cnt_q == '0) status_d = ST_ABSENT;
          end
          REQ_QUERY: begin
            is_run_d = run_vld_q && (run_q == pid_q);
          end
          default: ;
        endcase
      end
      S_POP: begin
        // Ready head was read at head_q during the previous cycle.
        run_d     = ready_rd_q;
        run_vld_d = 1'b1;
        head_d    = head_inc;
        rq_cnt_d  = rq_cnt_q - CW'(1);
      end
      S_SCMP: begin
        // Compare one entry per cycle while the next one is being read.
        if (found) begin
          if (run_vld_q && rq_full) begin
            status_d = ST_FULL;
          end else begin
            if (run_vld_q) begin
              ready_we = 1'b1;
              ready_wd = run_q;
              tail_d   = tail_inc;
              rq_cnt_d = rq_cnt_q + CW'(1);
            end
            run_d     = pid_q;
            run_vld_d = 1'b1;
            bl_cnt_d  = bl_cnt_q - CW'(1);
          end
        end else begin
          idx_d = idx_inc;
          if (idx_inc >= bl_cnt_q) status_d = ST_ABSENT;
        end
      end
      S_SHIFT: begin
        // Move the following entry down by one place and read the next.
        blk_we = 1'b1;
        blk_ra = idx_inc2[PW-1:0];
        idx_d  = idx_inc;
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      id_cnt_q  <= '0;
      run_q     <= '0;
      run_vld_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      rq_cnt_q  <= '0;
      bl_cnt_q  <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      id_cnt_q  <= id_cnt_d;
      run_q     <= run_d;
      run_vld_q <= run_vld_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      rq_cnt_q  <= rq_cnt_d;
      bl_cnt_q  <= bl_cnt_d;
      idx_q     <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pid_q    <= pid_d;
    new_id_q <= new_id_d;
    is_run_q <= is_run_d;
    status_q <= status_d;
  end

  // Ready queue memory; the head entry is read every cycle.
  always_ff @(posedge clk_i) begin
    if (ready_we) ready_mem[ready_wa] <= ready_wd;
    ready_rd_q <= ready_mem[head_q];
  end

  // Blocked list memory.
  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_rd_q <= blk_mem[blk_ra];
  end

  // Result ports.
  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_RESP);
  assign new_id_o     = new_id_q;
  assign is_running_o = is_run_q;
  assign busy_res_o   = run_vld_q;
  assign current_id_o = run_vld_q ? PidW'(run_q) : '0;
  assign status_o     = status_q;

  // The result strobe lasts a single cycle.
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // A transfer always starts work in the following cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("request transfer did not start work");

  // The fill counts never exceed the depth of their stores.
  a_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rq_cnt_q <= CW'(QUEUE_DEPTH)) && (bl_cnt_q <= CW'(QUEUE_DEPTH)))
    else $error("queue count out of range");

  // An idle processor holds identifier zero.
  a_idle_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_vld_q |-> (run_q == '0))
    else $error("idle with non-zero running identifier");

endmodule
